FILE: sv/phv_pkg.sv
// shared types and constants for the program header validator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package phv_pkg;

  localparam int unsigned MAX_LOAD_DEF = 16;
  localparam int unsigned QDEPTH       = 2;

  localparam int unsigned CFG_IW = 8;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_BYTES    = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_INTERP_ALLOWED = CFG_IW'(1);

  localparam logic [31:0] SEG_LOAD    = 32'h0000_0001;
  localparam logic [31:0] SEG_DYNAMIC = 32'h0000_0002;
  localparam logic [31:0] SEG_INTERP  = 32'h0000_0003;
  localparam logic [31:0] SEG_STACK   = 32'h6474_e551;

  localparam logic [31:0] PERM_X = 32'h0000_0001;
  localparam logic [31:0] PERM_W = 32'h0000_0002;
  localparam logic [31:0] PERM_R = 32'h0000_0004;

  localparam logic [63:0] DYN_ENTRY_MASK = 64'h0000_0000_0000_000f;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_SEGMENT = 2'd1,
    ERR_POLICY  = 2'd2,
    ERR_DYNAMIC = 2'd3
  } phv_err_e;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_LOAD,
    KIND_DYNAMIC,
    KIND_INTERP,
    KIND_STACK
  } phv_kind_e;

  typedef struct packed {
    logic [31:0] seg_kind;
    logic [31:0] seg_perm;
    logic [63:0] file_pos;
    logic [63:0] virt_addr;
    logic [63:0] phys_addr;
    logic [63:0] file_len;
    logic [63:0] mem_len;
    logic [63:0] alignment;
    logic        last_header;
  } phv_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] load_total;
    logic [4:0] writable_total;
    logic [4:0] exec_total;
    logic [4:0] wx_total;
    logic       saw_interp;
    logic       saw_dynamic;
    logic       saw_stack;
    logic       image_done;
  } phv_out_t;

  typedef struct packed {
    logic [63:0] image_bytes;
    logic        interp_allowed;
  } phv_cfg_t;

  // outcome of the stateless checks on one header
  typedef struct packed {
    phv_kind_e kind;
    logic      load_ok;
    logic      interp_ok;
    logic      dyn_ok;
    logic      stack_ok;
    logic      perm_w;
    logic      perm_x;
    logic      last;
  } phv_class_t;

endpackage

FILE: sv/phv_front.sv
// front end: accepts headers and runs the stateless field checks
// depends on phv_pkg
`timescale 1ns / 1ps

module phv_front import phv_pkg::*; (
  input  phv_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  phv_in_t    in_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output phv_class_t q_data_o
);

  logic [63:0] room;
  logic        fits;
  logic [63:0] al_m1;
  logic        al_pow2;
  logic [63:0] va_diff;
  logic        align_bad;
  logic        stack_zero;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    room       = cfg_i.image_bytes - in_data_i.file_pos;
    fits       = (in_data_i.file_pos <= cfg_i.image_bytes) && (in_data_i.file_len <= room);
    al_m1      = in_data_i.alignment - 64'd1;
    al_pow2    = (in_data_i.alignment != 64'd0) && ((in_data_i.alignment & al_m1) == 64'd0);
    va_diff    = in_data_i.virt_addr - in_data_i.file_pos;
    align_bad  = (in_data_i.alignment > 64'd1) && (!al_pow2 || ((va_diff & al_m1) != 64'd0));
    stack_zero = (in_data_i.file_pos == 64'd0) && (in_data_i.virt_addr == 64'd0) &&
                 (in_data_i.phys_addr == 64'd0) && (in_data_i.file_len == 64'd0) &&
                 (in_data_i.mem_len == 64'd0);

    case (in_data_i.seg_kind)
      SEG_LOAD:    q_data_o.kind = KIND_LOAD;
      SEG_DYNAMIC: q_data_o.kind = KIND_DYNAMIC;
      SEG_INTERP:  q_data_o.kind = KIND_INTERP;
      SEG_STACK:   q_data_o.kind = KIND_STACK;
      default:     q_data_o.kind = KIND_OTHER;
    endcase

    q_data_o.load_ok   = (in_data_i.file_len <= in_data_i.mem_len) && fits && !align_bad;
    q_data_o.interp_ok = cfg_i.interp_allowed && fits;
    q_data_o.dyn_ok    = fits && ((in_data_i.file_len & DYN_ENTRY_MASK) == 64'd0);
    q_data_o.stack_ok  = (in_data_i.seg_perm == (PERM_R | PERM_W)) && stack_zero &&
                         ((in_data_i.alignment == 64'd0) || al_pow2);
    q_data_o.perm_w    = (in_data_i.seg_perm & PERM_W) != 32'd0;
    q_data_o.perm_x    = (in_data_i.seg_perm & PERM_X) != 32'd0;
    q_data_o.last      = in_data_i.last_header;
  end

endmodule

FILE: sv/phv_queue.sv
// short register queue of classified headers between front and back
// depends on phv_pkg
`timescale 1ns / 1ps

module phv_queue import phv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  phv_class_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output phv_class_t pop_data_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  phv_class_t          mem_q [QDEPTH];
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;

  assign full_o     = count_q == CW'(QDEPTH);
  assign valid_o    = count_q != CW'(0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? PW'(0) : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? PW'(0) : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/phv_back.sv
// back end: applies a classified header to the image state, holds the result word
// depends on phv_pkg
`timescale 1ns / 1ps

module phv_back import phv_pkg::*; #(
  parameter int unsigned MAX_LOAD = MAX_LOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  phv_class_t q_data_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output phv_out_t   out_data_o
);

  localparam int unsigned NW = $clog2(MAX_LOAD + 1);
  localparam int unsigned CW = (NW > 5) ? NW : 5;

  logic [CW-1:0] load_q, load_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] ex_q, ex_d;
  logic [CW-1:0] wx_q, wx_d;
  logic          interp_q, interp_d;
  logic          dyn_q, dyn_d;
  logic          stack_q, stack_d;
  phv_err_e      err_q, err_d;
  logic          out_valid_q;
  phv_out_t      out_q, out_d;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    load_d   = load_q;
    wr_d     = wr_q;
    ex_d     = ex_q;
    wx_d     = wx_q;
    interp_d = interp_q;
    dyn_d    = dyn_q;
    stack_d  = stack_q;
    err_d    = err_q;

    if (err_q == ERR_NONE) begin
      case (q_data_i.kind)
        KIND_LOAD: begin
          if (!q_data_i.load_ok) begin
            err_d = ERR_SEGMENT;
          end else if (load_q >= CW'(MAX_LOAD)) begin
            err_d = ERR_POLICY;
          end else begin
            load_d = load_q + CW'(1);
            if (q_data_i.perm_w) wr_d = wr_q + CW'(1);
            if (q_data_i.perm_x) ex_d = ex_q + CW'(1);
            if (q_data_i.perm_w && q_data_i.perm_x) wx_d = wx_q + CW'(1);
          end
        end
        KIND_INTERP: begin
          if (interp_q || !q_data_i.interp_ok) err_d = ERR_POLICY;
          else interp_d = 1'b1;
        end
        KIND_DYNAMIC: begin
          if (dyn_q || !q_data_i.dyn_ok) err_d = ERR_DYNAMIC;
          else dyn_d = 1'b1;
        end
        KIND_STACK: begin
          if (stack_q || !q_data_i.stack_ok) err_d = ERR_POLICY;
          else stack_d = 1'b1;
        end
        default: ;
      endcase
    end

    // final header of an image without any load segment
    if (q_data_i.last && (err_d == ERR_NONE) && (load_d == CW'(0))) begin
      err_d = ERR_SEGMENT;
    end

    out_d.status         = err_d;
    out_d.load_total     = load_d[4:0];
    out_d.writable_total = wr_d[4:0];
    out_d.exec_total     = ex_d[4:0];
    out_d.wx_total       = wx_d[4:0];
    out_d.saw_interp     = interp_d;
    out_d.saw_dynamic    = dyn_d;
    out_d.saw_stack      = stack_d;
    out_d.image_done     = q_data_i.last;

    if (q_data_i.last) begin
      load_d   = '0;
      wr_d     = '0;
      ex_d     = '0;
      wx_d     = '0;
      interp_d = 1'b0;
      dyn_d    = 1'b0;
      stack_d  = 1'b0;
      err_d    = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q      <= '0;
      wr_q        <= '0;
      ex_q        <= '0;
      wx_q        <= '0;
      interp_q    <= 1'b0;
      dyn_q       <= 1'b0;
      stack_q     <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        load_q   <= load_d;
        wr_q     <= wr_d;
        ex_q     <= ex_d;
        wx_q     <= wx_d;
        interp_q <= interp_d;
        dyn_q    <= dyn_d;
        stack_q  <= stack_d;
        err_q    <= err_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wx_q <= wr_q) && (wx_q <= ex_q) && (wr_q <= load_q) && (ex_q <= load_q))
    else $error("permission counts exceed load count");

  a_load_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q <= CW'(MAX_LOAD))
    else $error("load count above limit");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_data_i.last) |=> (load_q == CW'(0)) && (err_q == ERR_NONE) &&
                                   !interp_q && !dyn_q && !stack_q)
    else $error("state not cleared after final header");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && (err_q != ERR_NONE) && !q_data_i.last) |=>
      (err_q == $past(err_q)) && (load_q == $past(load_q)))
    else $error("state changed after first error");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !q_pop_o)
    else $error("pending result word overwritten");

endmodule

FILE: sv/program_header_validator.sv
// top level of the program header validator: configuration registers and wiring
// depends on phv_pkg, phv_front, phv_queue, phv_back
`timescale 1ns / 1ps

// Checks a stream of 64-bit program headers, one word per header, against the
// configured image size and returns one result word per header carrying the
// sticky first error and the running load/permission counts of the current
// image. The block sustains one header per clock while results are taken:
// the front end classifies a header in the cycle it is accepted and drops it
// into a two-entry queue, and the back end folds one queued header per cycle
// into the image state while its result word is free. Headers are accepted
// while the queue has room, so a waiting result word does not block input
// until the queue fills. Configuration (index 0 image size, index 1
// interpreter enable) is written through the plain write port; the user must
// write it only while the block is idle, which the block itself does not
// enforce. Writes to other indexes are ignored. The final header of an image
// reports, then returns all image state to reset, keeping the configuration.
module program_header_validator import phv_pkg::*; #(
  parameter int unsigned MAX_LOAD = MAX_LOAD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  phv_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output phv_out_t          out_data_o
);

  phv_cfg_t   cfg_q;
  logic       q_full;
  logic       q_push;
  phv_class_t q_wdata;
  logic       q_pop;
  logic       q_valid;
  phv_class_t q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_BYTES:    cfg_q.image_bytes    <= cfg_data_i;
        CFG_INTERP_ALLOWED: cfg_q.interp_allowed <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  phv_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  phv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  phv_back #(
    .MAX_LOAD (MAX_LOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
